// ===== rtl/core/afs_pkg.sv =====
package afs_pkg;

  localparam int HEADER_BYTES = 7;

  localparam logic [7:0] SYNC_BYTE   = 8'hFF;
  localparam logic [7:0] SYNC_SECOND = 8'hF1;
  localparam logic [3:0] SYNC_NIBBLE = 4'hF;

  localparam logic [12:0] MAX_FRAME_RESET = 13'd8191;
  localparam logic [12:0] HEADER_LEN      = 13'(HEADER_BYTES);
  localparam logic [2:0]  LAST_HDR_IDX    = 3'(HEADER_BYTES - 1);

  // result status codes
  localparam logic [2:0] ST_DATA     = 3'd0;
  localparam logic [2:0] ST_BAD_SYNC = 3'd1;
  localparam logic [2:0] ST_TOO_LONG = 3'd2;
  localparam logic [2:0] ST_SHORT    = 3'd3;
  localparam logic [2:0] ST_TRUNC    = 3'd4;
  localparam logic [2:0] ST_NO_SYNC  = 3'd5;

  typedef enum logic [1:0] {
    MODE_HUNT,
    MODE_HEADER,
    MODE_PAYLOAD
  } afs_mode_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       stream_end;
  } afs_in_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        frame_last;
    logic [12:0] frame_length;
    logic [2:0]  status;
  } afs_out_t;

  // Work handed from the parser to the emitter. A header command expands to
  // seven beats; an item command gives its item and, with trunc_after, a
  // truncation beat behind it.
  typedef struct packed {
    logic                               is_header;
    logic                               trunc_after;
    afs_out_t                           item;
    logic [HEADER_BYTES-1:0][7:0]       hdr;
  } afs_cmd_t;

endpackage

// ===== rtl/core/afs_front.sv =====
module afs_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  afs_pkg::afs_in_t in_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [12:0]      cfg_data,
  input  logic             q_full,
  output logic             q_push,
  output afs_pkg::afs_cmd_t q_cmd
);
  import afs_pkg::*;

  afs_mode_t   mode, mode_next;
  logic        prev_sync, prev_sync_next;
  logic [2:0]  hdr_cnt, hdr_cnt_next;
  logic [12:0] remaining, remaining_next;
  logic [12:0] cur_len, cur_len_next;
  logic [12:0] max_len;
  logic [7:0]  hdr_store [HEADER_BYTES];

  logic        accept;
  logic        hunt_hit;
  logic        hdr_done;
  logic        sync_ok;
  logic [12:0] hdr_len;
  logic [12:0] rem_dec;
  logic        pay_last;
  logic [7:0]  b;
  logic        eos;

  // hold both channels off while in reset
  assign in_ready  = !q_full && !rst;
  assign cfg_ready = !rst;
  assign accept    = in_valid && in_ready;
  assign b         = in_data.data_byte;
  assign eos       = in_data.stream_end;

  assign hunt_hit = prev_sync && (b == SYNC_SECOND);
  assign hdr_done = (hdr_cnt == LAST_HDR_IDX);
  assign sync_ok  = (hdr_store[0] == SYNC_BYTE) && (hdr_store[1][7:4] == SYNC_NIBBLE);
  assign hdr_len  = {hdr_store[3][1:0], hdr_store[4], hdr_store[5][7:5]};
  assign rem_dec  = (remaining != '0) ? remaining - 13'd1 : '0;
  assign pay_last = (rem_dec == '0);

  // next mode
  always_comb begin
    mode_next = mode;
    if (accept) begin
      unique case (mode)
        MODE_HUNT: begin
          if (hunt_hit && !eos) mode_next = MODE_HEADER;
        end
        MODE_HEADER: begin
          if (eos) begin
            mode_next = MODE_HUNT;
          end else if (hdr_done) begin
            if (!sync_ok || hdr_len > max_len || hdr_len < HEADER_LEN) begin
              mode_next = MODE_HUNT;
            end else if (hdr_len != HEADER_LEN) begin
              mode_next = MODE_PAYLOAD;
            end
          end
        end
        MODE_PAYLOAD: begin
          if (eos) mode_next = MODE_HUNT;
          else if (pay_last) mode_next = MODE_HEADER;
        end
        default: mode_next = MODE_HUNT;
      endcase
    end
  end

  // counters and commands
  always_comb begin
    prev_sync_next = prev_sync;
    hdr_cnt_next   = hdr_cnt;
    remaining_next = remaining;
    cur_len_next   = cur_len;
    q_push         = 1'b0;
    q_cmd          = '0;
    if (accept) begin
      unique case (mode)
        MODE_HUNT: begin
          if (hunt_hit) begin
            prev_sync_next = 1'b0;
            hdr_cnt_next   = 3'd2;
            if (eos) begin
              q_push             = 1'b1;
              q_cmd.item.status  = ST_TRUNC;
              hdr_cnt_next       = '0;
            end
          end else begin
            prev_sync_next = (b == SYNC_BYTE) && !eos;
            if (eos) begin
              q_push            = 1'b1;
              q_cmd.item.status = ST_NO_SYNC;
            end
          end
        end
        MODE_HEADER: begin
          if (!hdr_done) begin
            hdr_cnt_next = hdr_cnt + 3'd1;
            if (eos) begin
              q_push            = 1'b1;
              q_cmd.item.status = ST_TRUNC;
            end
          end else begin
            q_push                  = 1'b1;
            q_cmd.item.frame_length = hdr_len;
            if (!sync_ok) begin
              q_cmd.item.frame_length = '0;
              q_cmd.item.status       = ST_BAD_SYNC;
            end else if (hdr_len > max_len) begin
              q_cmd.item.status = ST_TOO_LONG;
            end else if (hdr_len < HEADER_LEN) begin
              q_cmd.item.status = ST_SHORT;
            end else if (eos && hdr_len != HEADER_LEN) begin
              q_cmd.item.status = ST_TRUNC;
            end else begin
              q_cmd.is_header = 1'b1;
              q_cmd.item.status = ST_DATA;
              q_cmd.hdr = {b, hdr_store[5], hdr_store[4], hdr_store[3],
                           hdr_store[2], hdr_store[1], hdr_store[0]};
              if (hdr_len != HEADER_LEN && !eos) begin
                cur_len_next   = hdr_len;
                remaining_next = hdr_len - HEADER_LEN;
              end
            end
          end
          if (eos || hdr_done) hdr_cnt_next = '0;
        end
        MODE_PAYLOAD: begin
          q_push                  = 1'b1;
          q_cmd.item.out_byte     = b;
          q_cmd.item.frame_last   = pay_last;
          q_cmd.item.frame_length = cur_len;
          q_cmd.item.status       = ST_DATA;
          q_cmd.trunc_after       = eos && !pay_last;
          remaining_next          = rem_dec;
          if (pay_last || eos) begin
            hdr_cnt_next = '0;
            cur_len_next = '0;
          end
          if (eos) remaining_next = '0;
        end
        default: begin
          prev_sync_next = 1'b0;
          hdr_cnt_next   = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_HUNT;
      prev_sync <= 1'b0;
      hdr_cnt   <= '0;
      remaining <= '0;
      cur_len   <= '0;
      max_len   <= MAX_FRAME_RESET;
    end else begin
      mode      <= mode_next;
      prev_sync <= prev_sync_next;
      hdr_cnt   <= hdr_cnt_next;
      remaining <= remaining_next;
      cur_len   <= cur_len_next;
      if (cfg_valid && cfg_ready) max_len <= cfg_data;
    end
  end

  // header capture; the sync pair found in hunt fills the first two slots
  always_ff @(posedge clk) begin
    if (accept && mode == MODE_HUNT && hunt_hit) begin
      hdr_store[0] <= SYNC_BYTE;
      hdr_store[1] <= SYNC_SECOND;
    end else if (accept && mode == MODE_HEADER && !hdr_done) begin
      hdr_store[hdr_cnt] <= b;
    end
  end

endmodule

// ===== rtl/core/afs_queue.sv =====
module afs_queue #(
  parameter int DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  afs_pkg::afs_cmd_t  push_cmd,
  output logic               full,
  input  logic               pop,
  output afs_pkg::afs_cmd_t  pop_cmd,
  output logic               not_empty
);
  import afs_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  afs_cmd_t        slots [DEPTH];
  logic [AW-1:0]   wr_ptr, rd_ptr;
  logic [CW-1:0]   count;

  assign full      = (count == CW'(DEPTH));
  assign not_empty = (count != '0);
  assign pop_cmd   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      if (pop)  rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      if (push && !pop)      count <= count + CW'(1);
      else if (pop && !push) count <= count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_cmd;
  end

endmodule

// ===== rtl/core/afs_back.sv =====
module afs_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  afs_pkg::afs_cmd_t q_cmd,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output afs_pkg::afs_out_t out_data
);
  import afs_pkg::*;

  afs_cmd_t   cur;
  logic       cur_valid;
  logic [2:0] idx;
  afs_out_t   beat;
  logic       final_beat;
  logic       advance;

  // expand the current command into its beats
  always_comb begin
    beat = cur.item;
    if (cur.is_header) begin
      beat.out_byte   = cur.hdr[idx];
      beat.frame_last = (cur.item.frame_length == HEADER_LEN) && (idx == LAST_HDR_IDX);
      beat.status     = ST_DATA;
      final_beat      = (idx == LAST_HDR_IDX);
    end else begin
      if (idx != '0) begin
        beat.out_byte   = '0;
        beat.frame_last = 1'b0;
        beat.status     = ST_TRUNC;
      end
      final_beat = (idx != '0) || !cur.trunc_after;
    end
  end

  assign advance = cur_valid && (!out_valid || out_ready);
  assign q_pop   = q_valid && (!cur_valid || (advance && final_beat));

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (advance) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (q_pop) begin
        cur_valid <= 1'b1;
        idx       <= '0;
      end else if (advance) begin
        if (final_beat) cur_valid <= 1'b0;
        idx <= idx + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur <= q_cmd;
    if (advance) out_data <= beat;
  end

endmodule

// ===== rtl/core/adts_frame_splitter_unit.sv =====
// ADTS frame splitter.
// in_*: one stream byte per beat with a stream_end flag. out_*: frame bytes,
// header first then payload, frame_last on the final byte; error and
// truncation beats carry a nonzero status and a zero byte.
// cfg_*: writes max_frame_bytes; ready except during reset, write only while idle.
// A parser classifies each byte and posts a command into a QUEUE_DEPTH-entry
// queue (two by default); an emitter expands commands into output beats
// through an output register. Throughput: one byte per cycle through hunt
// and payload while the queue has room; a complete header turns into a burst
// of seven beats, one per cycle while out_ready is high, during which the
// queue can fill and in_ready drop until the emitter catches up.
// When out_ready is low the output beat holds, the emitter stalls, and once
// the queue is full in_ready goes low; nothing is lost or repeated.
// Reset (synchronous rst): hunt mode, queue and output empty, max_frame_bytes
// back to 8191. No clearing pass is needed.
module adts_frame_splitter_unit #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  afs_pkg::afs_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output afs_pkg::afs_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [12:0]       cfg_data
);
  import afs_pkg::*;

  logic     q_full, q_push, q_pop, q_nonempty;
  afs_cmd_t push_cmd, pop_cmd;

  afs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (push_cmd)
  );

  afs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .pop_cmd   (pop_cmd),
    .not_empty (q_nonempty)
  );

  afs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_nonempty),
    .q_cmd     (pop_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== test/tb_adts_frame_splitter_unit.sv =====
module tb_adts_frame_splitter_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import afs_pkg::*;

  // Frame-level mirror of the splitter: parses the accepted byte stream and
  // queues the beats it should produce.
  class afs_frame_scoreboard;
    afs_out_t    expected_beats[$];
    afs_mode_t   mode;
    bit          prev_ff;
    logic [7:0]  hdr [HEADER_BYTES];
    int unsigned hdr_count;
    int unsigned bytes_left;
    logic [12:0] frame_len;
    logic [12:0] max_len;
    int unsigned fail_count;
    int unsigned bytes_in;
    int unsigned beats_ok;
    int unsigned status_seen [8];

    function new();
      max_len = MAX_FRAME_RESET;
      foreach (hdr[i]) hdr[i] = 8'h00;
      foreach (status_seen[i]) status_seen[i] = 0;
      fail_count = 0;
      bytes_in = 0;
      beats_ok = 0;
      go_hunt();
    endfunction

    function void go_hunt();
      mode = MODE_HUNT;
      prev_ff = 1'b0;
      hdr_count = 0;
      bytes_left = 0;
      frame_len = '0;
    endfunction

    function void set_max(logic [12:0] v);
      max_len = v;
    endfunction

    function void post(logic [7:0] b, bit last, logic [12:0] len, logic [2:0] st);
      afs_out_t r;
      r.out_byte = b;
      r.frame_last = last;
      r.frame_length = len;
      r.status = st;
      expected_beats.push_back(r);
    endfunction

    function void flag(string msg);
      fail_count++;
      if (fail_count <= 10) $display("[%0t] %s", $realtime, msg);
    endfunction

    function void note_byte(afs_in_t x);
      logic [12:0] len;
      bit last;
      int i;
      bytes_in++;
      case (mode)
        MODE_HUNT: begin
          if (prev_ff && x.data_byte == SYNC_SECOND) begin
            hdr[0] = SYNC_BYTE;
            hdr[1] = SYNC_SECOND;
            hdr_count = 2;
            prev_ff = 1'b0;
            mode = MODE_HEADER;
            if (x.stream_end) begin
              post(8'h00, 1'b0, 13'd0, ST_TRUNC);
              go_hunt();
            end
          end else begin
            prev_ff = (x.data_byte == SYNC_BYTE);
            if (x.stream_end) begin
              post(8'h00, 1'b0, 13'd0, ST_NO_SYNC);
              go_hunt();
            end
          end
        end
        MODE_HEADER: begin
          hdr[hdr_count] = x.data_byte;
          hdr_count++;
          if (hdr_count < HEADER_BYTES) begin
            if (x.stream_end) begin
              post(8'h00, 1'b0, 13'd0, ST_TRUNC);
              go_hunt();
            end
          end else begin
            hdr_count = 0;
            len = {hdr[3][1:0], hdr[4], hdr[5][7:5]};
            if (hdr[0] != SYNC_BYTE || hdr[1][7:4] != SYNC_NIBBLE) begin
              post(8'h00, 1'b0, 13'd0, ST_BAD_SYNC);
              go_hunt();
            end else if (len > max_len) begin
              post(8'h00, 1'b0, len, ST_TOO_LONG);
              go_hunt();
            end else if (len < HEADER_LEN) begin
              post(8'h00, 1'b0, len, ST_SHORT);
              go_hunt();
            end else if (x.stream_end && len > HEADER_LEN) begin
              // header complete but payload cut off: no header beats
              post(8'h00, 1'b0, len, ST_TRUNC);
              go_hunt();
            end else begin
              for (i = 0; i < HEADER_BYTES; i++)
                post(hdr[i], len == HEADER_LEN && i == HEADER_BYTES - 1, len, ST_DATA);
              if (len == HEADER_LEN) begin
                mode = MODE_HEADER;
                frame_len = '0;
                bytes_left = 0;
              end else begin
                mode = MODE_PAYLOAD;
                frame_len = len;
                bytes_left = int'(len) - HEADER_BYTES;
              end
              if (x.stream_end) go_hunt();
            end
          end
        end
        default: begin
          len = frame_len;
          if (bytes_left > 0) bytes_left--;
          last = (bytes_left == 0);
          post(x.data_byte, last, len, ST_DATA);
          if (last) begin
            // next header follows directly, no hunt
            mode = MODE_HEADER;
            hdr_count = 0;
            frame_len = '0;
          end
          if (x.stream_end) begin
            if (!last) post(8'h00, 1'b0, len, ST_TRUNC);
            go_hunt();
          end
        end
      endcase
    endfunction

    function void check_beat(afs_out_t got);
      afs_out_t want;
      if (expected_beats.size() == 0) begin
        flag($sformatf("unexpected beat: byte %02h last %0b len %0d status %0d",
                       got.out_byte, got.frame_last, got.frame_length, got.status));
        return;
      end
      want = expected_beats.pop_front();
      if (got.out_byte !== want.out_byte || got.frame_last !== want.frame_last ||
          got.frame_length !== want.frame_length || got.status !== want.status) begin
        flag($sformatf({"beat mismatch: expected byte %02h last %0b len %0d status %0d,",
                        " got byte %02h last %0b len %0d status %0d"},
                       want.out_byte, want.frame_last, want.frame_length, want.status,
                       got.out_byte, got.frame_last, got.frame_length, got.status));
      end else begin
        beats_ok++;
        status_seen[want.status]++;
      end
    endfunction

    function void flush_leftover();
      afs_out_t want;
      while (expected_beats.size() != 0) begin
        want = expected_beats.pop_front();
        flag($sformatf("missing beat: byte %02h last %0b len %0d status %0d",
                       want.out_byte, want.frame_last, want.frame_length, want.status));
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  afs_in_t     in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  afs_out_t    out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [12:0] cfg_data = '0;

  afs_frame_scoreboard sb = new();
  afs_in_t     stream_q[$];
  logic [12:0] cur_max = MAX_FRAME_RESET;
  bit          idle_on = 1'b1;
  int unsigned gap_pct = 15;
  int unsigned cfg_writes = 0;

  adts_frame_splitter_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin : watchdog
    #2ms;
    $display("tb_adts_frame_splitter_unit: done, errors");
    $finish;
  end

  // Result side: check each accepted beat, stall in short bursts with calm
  // stretches in between.
  initial begin : result_side
    int unsigned stall_left;
    int unsigned calm_left;
    stall_left = 0;
    calm_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) sb.check_beat(out_data);
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (calm_left > 0) begin
        calm_left--;
        out_ready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 49) == 0) begin
        calm_left = $urandom_range(20, 60);
        out_ready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 3);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic push_byte(input afs_in_t x);
    if (idle_on && gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= x;
    do @(posedge clk); while (!in_ready);
    sb.note_byte(x);
  endtask

  task automatic play_stream();
    foreach (stream_q[i]) push_byte(stream_q[i]);
    stream_q.delete();
  endtask

  // Drop valid, wait for every expected beat, then let the pipe run dry.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.expected_beats.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_max(input logic [12:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_max(v);
    cur_max = v;
    cfg_writes++;
  endtask

  function automatic void add_byte(logic [7:0] b);
    afs_in_t x;
    x.data_byte = b;
    x.stream_end = 1'b0;
    stream_q.push_back(x);
  endfunction

  function automatic void add_noise(int unsigned n);
    repeat (n) add_byte(($urandom_range(0, 3) == 0) ? SYNC_BYTE : 8'($urandom));
  endfunction

  // Header carrying len, then the payload if the block should take the frame.
  function automatic void add_frame(logic [12:0] len, bit chained, bit bad);
    logic [7:0] h [HEADER_BYTES];
    h[0] = SYNC_BYTE;
    h[1] = chained ? {SYNC_NIBBLE, 4'($urandom)} : SYNC_SECOND;
    if (bad) begin
      if ($urandom_range(0, 1) == 0) h[0] = 8'($urandom_range(0, 254));
      else h[1] = {4'($urandom_range(0, 14)), 4'($urandom)};
    end
    h[2] = 8'($urandom);
    h[3] = {6'($urandom), len[12:11]};
    h[4] = len[10:3];
    h[5] = {len[2:0], 5'($urandom)};
    h[6] = 8'($urandom);
    foreach (h[i]) add_byte(h[i]);
    if (!bad && len >= HEADER_LEN && len <= cur_max)
      repeat (int'(len) - HEADER_BYTES) add_byte(8'($urandom));
  endfunction

  // Flag the end of the stream on the last byte, or cut the stream at cut.
  function automatic void close_stream(int cut);
    if (cut >= 0)
      while (stream_q.size() > cut + 1) void'(stream_q.pop_back());
    stream_q[stream_q.size() - 1].stream_end = 1'b1;
  endfunction

  task automatic run_random(input int unsigned target);
    int unsigned done_items;
    int unsigned noise_n;
    int unsigned pick;
    int unsigned hi;
    int cut;
    bit chained;
    bit bad;
    logic [12:0] len;
    done_items = 0;
    while (done_items < target) begin
      gap_pct = ($urandom_range(0, 3) == 0) ? 0 : 15;
      noise_n = $urandom_range(0, 3);
      add_noise(noise_n);
      chained = 1'b0;
      repeat ($urandom_range(1, 4)) begin
        pick = $urandom_range(0, 19);
        bad = 1'b0;
        if (pick == 15 || pick == 16) begin
          if (cur_max < MAX_FRAME_RESET)
            len = ($urandom_range(0, 1) == 0) ? MAX_FRAME_RESET :
                  13'($urandom_range(int'(cur_max) + 1, int'(MAX_FRAME_RESET)));
          else
            len = 13'($urandom_range(0, 6));
        end else if (pick == 17) begin
          len = 13'($urandom_range(0, 6));
        end else begin
          bad = chained && pick >= 18;
          if (cur_max < HEADER_LEN) begin
            len = 13'($urandom_range(7, 40));
          end else begin
            hi = ($urandom_range(0, 7) == 0) ? 300 : 24;
            if (hi > cur_max) hi = 32'(cur_max);
            len = 13'($urandom_range(7, hi));
          end
        end
        add_frame(len, chained, bad);
        chained = !bad && len >= HEADER_LEN && len <= cur_max;
      end
      cut = -1;
      if ($urandom_range(0, 3) == 0) cut = $urandom_range(noise_n, stream_q.size() - 1);
      close_stream(cut);
      if (stream_q.size() > noise_n) done_items += stream_q.size() - noise_n;
      play_stream();
    end
  endtask

  initial begin : stimulus
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    write_max(MAX_FRAME_RESET);

    // lone byte ending the stream in hunt
    add_byte(8'h00);
    close_stream(-1);
    play_stream();
    // sync pair with end on the second sync byte
    add_byte(SYNC_BYTE);
    add_byte(SYNC_BYTE);
    add_byte(SYNC_SECOND);
    close_stream(-1);
    play_stream();
    // end inside a header
    add_frame(13'd20, 1'b0, 1'b0);
    close_stream(4);
    play_stream();
    // header-only frame, one-byte payload frame, bad sync, then end in hunt
    add_frame(13'd7, 1'b0, 1'b0);
    add_frame(13'd8, 1'b1, 1'b0);
    add_frame(13'd9, 1'b1, 1'b1);
    add_byte(SYNC_BYTE);
    close_stream(-1);
    play_stream();
    // short frames, then a header-only frame finishing on the end byte
    add_frame(13'd0, 1'b0, 1'b0);
    add_frame(13'd6, 1'b0, 1'b0);
    add_frame(13'd7, 1'b0, 1'b0);
    close_stream(-1);
    play_stream();
    // end on the last payload byte
    add_frame(13'd12, 1'b0, 1'b0);
    close_stream(-1);
    play_stream();
    // end in the middle of the payload
    add_frame(13'd12, 1'b0, 1'b0);
    close_stream(9);
    play_stream();
    // end on a complete header with payload due
    add_frame(13'd10, 1'b0, 1'b0);
    close_stream(6);
    play_stream();
    // largest length, cut short
    add_frame(MAX_FRAME_RESET, 1'b0, 1'b0);
    close_stream(11);
    play_stream();

    run_random(45);

    settle();
    write_max(13'd2);
    run_random(15);

    settle();
    write_max(HEADER_LEN);
    run_random(20);

    settle();
    write_max(13'($urandom_range(8, 40)));
    run_random(45);

    // last part runs without idling on either side
    settle();
    write_max(MAX_FRAME_RESET - 13'd1);
    idle_on = 1'b0;
    run_random(40);

    settle();
    sb.flush_leftover();
    $display("covered %0d stream bytes across %0d max_frame_bytes settings (2 up to 8191)",
             sb.bytes_in, cfg_writes);
    $display({"%0d beats matched: %0d data, %0d bad sync, %0d too long, %0d short,",
              " %0d truncated, %0d no sync; %0d failures"},
             sb.beats_ok, sb.status_seen[ST_DATA], sb.status_seen[ST_BAD_SYNC],
             sb.status_seen[ST_TOO_LONG], sb.status_seen[ST_SHORT],
             sb.status_seen[ST_TRUNC], sb.status_seen[ST_NO_SYNC], sb.fail_count);
    if (sb.fail_count == 0) begin
      $display("tb_adts_frame_splitter_unit: done, clean");
    end else begin
      $display("tb_adts_frame_splitter_unit: done, errors");
    end
    $finish;
  end

endmodule
